/* sv/lcdns_pkg.sv */
// ============================================================================
// lcdns_pkg
// Types, command codes and the fixed init nibble table for the character LCD
// nibble sequencer.
// ============================================================================
`default_nettype none

package lcdns_pkg;

    // Request command codes carried in the input tuser field.
    localparam logic [1:0] CMD_INIT   = 2'd0;
    localparam logic [1:0] CMD_INSTR  = 2'd1;
    localparam logic [1:0] CMD_DATA   = 2'd2;
    localparam logic [1:0] CMD_CURSOR = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SETUP     = 2'd0;
    localparam logic [1:0] CFG_EN_HIGH   = 2'd1;
    localparam logic [1:0] CFG_EN_LOW    = 2'd2;
    localparam logic [1:0] CFG_LONG_WAIT = 2'd3;

    // Configuration reset values.
    localparam logic [9:0]  SETUP_RST     = 10'd100;
    localparam logic [9:0]  EN_HIGH_RST   = 10'd1;
    localparam logic [9:0]  EN_LOW_RST    = 10'd80;
    localparam logic [13:0] LONG_WAIT_RST = 14'd2000;

    // Instruction bytes that need the long wait afterward.
    localparam logic [7:0] INSTR_CLEAR = 8'h01;
    localparam logic [7:0] INSTR_HOME  = 8'h02;

    // Set DDRAM address opcode bit.
    localparam logic DDRAM_OP = 1'b1;

    // The init sequence is twelve nibbles: four wake-up nibbles, then four bytes.
    localparam int          INIT_NIBBLES = 12;
    localparam logic [3:0]  INIT_LAST    = 4'(INIT_NIBBLES - 1);

    // Extra holds in the wake-up part of the init sequence.
    localparam logic [15:0] POWER_ON_US  = 16'd50000;
    localparam logic [15:0] FIRST_WAKE_US = 16'd5000;
    localparam logic [15:0] NEXT_WAKE_US = 16'd150;

    // One queued job for the back end.
    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] byte_val;
        logic       long_wait;
    } job_t;

    // Configuration values as seen by the back end.
    typedef struct packed {
        logic [9:0]  setup_us;
        logic [9:0]  en_high_us;
        logic [9:0]  en_low_us;
        logic [13:0] long_wait_us;
    } cfg_t;

    // One nibble of the init sequence with its extra holds.
    typedef struct packed {
        logic [3:0]  nibble;
        logic [15:0] pre_us;
        logic [15:0] post_us;
    } nib_info_t;

    // Phase of the pin-event sequencer within one nibble.
    typedef enum logic [1:0] {
        PH_SETUP,
        PH_EN_HIGH,
        PH_EN_LOW,
        PH_LONG_WAIT
    } phase_t;

    // Init sequence: 3, 3, 3, 2 then the bytes 0x28, 0x0C, 0x06 and 0x01.
    function automatic nib_info_t init_nibble(input logic [3:0] idx);
        nib_info_t info;
        info.pre_us  = 16'd0;
        info.post_us = 16'd0;
        case (idx)
            4'd0:
            begin
                info.nibble  = 4'h3;
                info.pre_us  = POWER_ON_US;
                info.post_us = FIRST_WAKE_US;
            end
            4'd1, 4'd2:
            begin
                info.nibble  = 4'h3;
                info.post_us = NEXT_WAKE_US;
            end
            4'd3:
            begin
                info.nibble  = 4'h2;
                info.post_us = NEXT_WAKE_US;
            end
            4'd4:  info.nibble = 4'h2;
            4'd5:  info.nibble = 4'h8;
            4'd6:  info.nibble = 4'h0;
            4'd7:  info.nibble = 4'hC;
            4'd8:  info.nibble = 4'h0;
            4'd9:  info.nibble = 4'h6;
            4'd10: info.nibble = 4'h0;
            4'd11: info.nibble = 4'h1;
            default: info.nibble = 4'h0;
        endcase
        return info;
    endfunction

endpackage

`default_nettype wire

/* sv/char_lcd_nibble_sequencer.sv */
// ============================================================================
// char_lcd_nibble_sequencer
// Character LCD controller for a 4-bit bus: turns requests into timed pin
// events (register select, data nibble, enable level, hold time).
// ============================================================================
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: command; tdata: byte_value, column, row_index
//  m_axis    out        tuser: register_select; tdata: data_nibble, enable,
//                       hold_us; tlast: last
//  cfg       in         cfg_index selects the register, cfg_data the value
//
//  The sequencer gives one pin event per cycle while m_axis is not stalled: a
//  byte request gives 6 events, 7 for clear or home, and an init request 37.
//  A two-entry job queue lets requests be taken while events are still going out.
//  A stall on m_axis holds the output word and the sequencer; the queue keeps
//  taking requests until it is full.
//  Reset is asynchronous; no clearing pass is needed after it.
// ============================================================================
`default_nettype none

module char_lcd_nibble_sequencer
    import lcdns_pkg::*;
#(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // byte_value, column, row_index
    input  wire logic [1:0]  s_axis_tuser,  // command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // data_nibble, enable, hold_us, zero fill
    output logic             m_axis_tuser,  // register_select
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [13:0] cfg_data
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    job_t        front_job;
    job_t        q_job;
    logic        q_valid;
    logic        q_ready;
    logic [3:0]  ev_nibble;
    logic        ev_enable;
    logic [15:0] ev_hold;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SETUP:     cfg_next.setup_us     = cfg_data[9:0];
                CFG_EN_HIGH:   cfg_next.en_high_us   = cfg_data[9:0];
                CFG_EN_LOW:    cfg_next.en_low_us    = cfg_data[9:0];
                CFG_LONG_WAIT: cfg_next.long_wait_us = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setup_us     <= SETUP_RST;
            cfg_reg.en_high_us   <= EN_HIGH_RST;
            cfg_reg.en_low_us    <= EN_LOW_RST;
            cfg_reg.long_wait_us <= LONG_WAIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Request classifier.
    lcdns_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .command    (s_axis_tuser),
        .byte_value (s_axis_tdata[7:0]),
        .column     (s_axis_tdata[13:8]),
        .row_index  (s_axis_tdata[15:14]),
        .job        (front_job)
    );

    // Job queue.
    lcdns_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (s_axis_tvalid),
        .wr_ready (s_axis_tready),
        .wr_job   (front_job),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_job   (q_job)
    );

    // Pin-event sequencer.
    lcdns_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_job      (q_job),
        .ev_valid   (m_axis_tvalid),
        .ev_ready   (m_axis_tready),
        .ev_rs      (m_axis_tuser),
        .ev_nibble  (ev_nibble),
        .ev_enable  (ev_enable),
        .ev_hold_us (ev_hold),
        .ev_last    (m_axis_tlast)
    );

    // Output word packing.
    assign m_axis_tdata = {3'd0, ev_hold, ev_enable, ev_nibble};

endmodule

`default_nettype wire

/* sv/lcdns_front.sv */
// ============================================================================
// lcdns_front
// Request classifier: turns one request into a job for the back end, forming
// the cursor address and flagging the long wait after clear and home.
// ============================================================================
`default_nettype none

module lcdns_front
    import lcdns_pkg::*;
#(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 2
)
(
    input  wire logic [1:0] command,
    input  wire logic [7:0] byte_value,
    input  wire logic [5:0] column,
    input  wire logic [1:0] row_index,
    output job_t            job
);

    localparam logic [5:0] COL_MAX = 6'(COLUMNS - 1);
    localparam logic [1:0] ROW_MAX = 2'(ROWS - 1);

    logic [5:0] col_c;
    logic [1:0] row_c;
    logic [6:0] addr;
    logic [7:0] instr;

    // Clamp the cursor position and build the DDRAM address.
    always_comb
    begin
        col_c = (column > COL_MAX) ? COL_MAX : column;
        row_c = (row_index > ROW_MAX) ? ROW_MAX : row_index;
        addr  = 7'({1'b0, col_c} + (7'(row_c) << 6));
    end

    // Pick the byte and register select for each command.
    always_comb
    begin
        job.is_init = 1'b0;
        job.rs      = 1'b0;
        instr       = byte_value;
        case (command)
            CMD_INIT:
            begin
                job.is_init = 1'b1;
                instr       = INSTR_CLEAR;
            end
            CMD_INSTR:  instr = byte_value;
            CMD_DATA:   job.rs = 1'b1;
            CMD_CURSOR: instr = {DDRAM_OP, addr};
            default:    instr = byte_value;
        endcase
        job.byte_val  = instr;
        // Clear and home need the long wait; data bytes never do.
        job.long_wait = !job.rs && (instr inside {INSTR_CLEAR, INSTR_HOME});
    end

endmodule

`default_nettype wire

/* sv/lcdns_queue.sv */
// ============================================================================
// lcdns_queue
// Two-entry job queue between the classifier and the pin-event sequencer.
// ============================================================================
`default_nettype none

module lcdns_queue
    import lcdns_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  wire job_t wr_job,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output job_t      rd_job
);

    job_t       mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_job   = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = 2'(count_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

/* sv/lcdns_back.sv */
// ============================================================================
// lcdns_back
// Pin-event sequencer: walks the nibbles of one job, three events per nibble
// and an optional long-wait event, into a registered output word.
// ============================================================================
`default_nettype none

module lcdns_back
    import lcdns_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  wire job_t        q_job,
    output logic             ev_valid,
    input  wire logic        ev_ready,
    output logic             ev_rs,
    output logic [3:0]       ev_nibble,
    output logic             ev_enable,
    output logic [15:0]      ev_hold_us,
    output logic             ev_last
);

    logic        active_reg;
    logic        active_next;
    job_t        job_reg;
    job_t        job_next;
    phase_t      phase_reg;
    phase_t      phase_next;
    logic [3:0]  nib_reg;
    logic [3:0]  nib_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_rs_reg;
    logic [3:0]  out_nibble_reg;
    logic        out_enable_reg;
    logic [15:0] out_hold_reg;
    logic        out_last_reg;

    nib_info_t   info;
    logic        last_nib;
    logic        step;
    logic        finish;
    logic        pop;
    logic [3:0]  cur_nibble;
    logic        cur_enable;
    logic [15:0] cur_hold;
    logic        cur_last;

    // Current nibble: from the init table or from the job's byte.
    always_comb
    begin
        info = init_nibble(nib_reg);
        if (!job_reg.is_init)
        begin
            info.nibble  = nib_reg[0] ? job_reg.byte_val[3:0] : job_reg.byte_val[7:4];
            info.pre_us  = 16'd0;
            info.post_us = 16'd0;
        end
        last_nib = job_reg.is_init ? (nib_reg == INIT_LAST) : (nib_reg == 4'd1);
    end

    // Event contents for the current phase. The holds stay below 65536 for
    // every register value, so no saturation is needed.
    always_comb
    begin
        cur_nibble = info.nibble;
        cur_enable = 1'b0;
        cur_hold   = 16'd0;
        cur_last   = 1'b0;
        case (phase_reg)
            PH_SETUP:
                cur_hold = 16'({6'd0, cfg.setup_us} + info.pre_us);
            PH_EN_HIGH:
            begin
                cur_enable = 1'b1;
                cur_hold   = {6'd0, cfg.en_high_us};
            end
            PH_EN_LOW:
            begin
                cur_hold = 16'({6'd0, cfg.en_low_us} + info.post_us);
                cur_last = last_nib && !job_reg.long_wait;
            end
            PH_LONG_WAIT:
            begin
                cur_hold = {2'd0, cfg.long_wait_us};
                cur_last = 1'b1;
            end
            default:
                cur_hold = 16'd0;
        endcase
    end

    // Handshake between job queue, sequencer and output register.
    assign step    = active_reg && (!out_valid_reg || ev_ready);
    assign finish  = step && cur_last;
    assign pop     = q_valid && (!active_reg || finish);
    assign q_ready = !active_reg || finish;

    // Next phase, nibble index and job.
    always_comb
    begin
        phase_next  = phase_reg;
        nib_next    = nib_reg;
        active_next = pop ? 1'b1 : (finish ? 1'b0 : active_reg);
        job_next    = pop ? q_job : job_reg;
        if (step)
        begin
            case (phase_reg)
                PH_SETUP:   phase_next = PH_EN_HIGH;
                PH_EN_HIGH: phase_next = PH_EN_LOW;
                PH_EN_LOW:
                begin
                    if (!last_nib)
                    begin
                        phase_next = PH_SETUP;
                        nib_next   = 4'(nib_reg + 4'd1);
                    end
                    else if (job_reg.long_wait)
                    begin
                        phase_next = PH_LONG_WAIT;
                    end
                    else
                    begin
                        phase_next = PH_SETUP;
                        nib_next   = 4'd0;
                    end
                end
                PH_LONG_WAIT:
                begin
                    phase_next = PH_SETUP;
                    nib_next   = 4'd0;
                end
                default:    phase_next = PH_SETUP;
            endcase
        end
    end

    // Output register valid.
    always_comb
    begin
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (ev_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            phase_reg     <= PH_SETUP;
            nib_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            phase_reg     <= phase_next;
            nib_reg       <= nib_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Job and output payload registers.
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (step)
        begin
            out_rs_reg     <= job_reg.rs;
            out_nibble_reg <= cur_nibble;
            out_enable_reg <= cur_enable;
            out_hold_reg   <= cur_hold;
            out_last_reg   <= cur_last;
        end
    end

    assign ev_valid   = out_valid_reg;
    assign ev_rs      = out_rs_reg;
    assign ev_nibble  = out_nibble_reg;
    assign ev_enable  = out_enable_reg;
    assign ev_hold_us = out_hold_reg;
    assign ev_last    = out_last_reg;

endmodule

`default_nettype wire
